// ===== rtl/core/kibs_pkg.sv =====
package kibs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int NUM_W    = 32;
    localparam int POS_W    = 48;
    localparam int FRAME_W  = 40;
    localparam int ADJ_W    = 48;
    localparam int KEY_W    = 40;
    localparam int DIST_W   = 16;
    localparam int STATUS_W = 2;

    // Signed compare width: covers a 48-bit unsigned adjusted frame and a
    // 33-bit signed number difference.
    localparam int CMP_W = ADJ_W + 2;

    // Divider: restoring, several quotient bits per cycle.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = FRAME_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // APB register map.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_DISTANCE = 2'd0;
    localparam logic [1:0] REG_SEARCH   = 2'd1;
    localparam logic [1:0] REG_DISC     = 2'd2;

    // Function codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_INCR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // One table row.
    typedef struct packed {
        logic [NUM_W-1:0]        num;
        logic [ADJ_W-1:0]        adj;
        logic signed [POS_W-1:0] pos;
    } row_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    exact;
        logic [SLOT_W-1:0]       lower_slot;
        logic [SLOT_W-1:0]       upper_slot;
        logic [KEY_W-1:0]        lower_key;
        logic [KEY_W-1:0]        upper_key;
        logic signed [POS_W-1:0] lower_pos;
        logic signed [POS_W-1:0] upper_pos;
    } result_t;

endpackage

// ===== rtl/core/kibs_if.sv =====
interface kibs_item_if;
    import kibs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [NUM_W-1:0]        entry_number;
    logic signed [POS_W-1:0] entry_pos;
    logic [FRAME_W-1:0]      desired_frame;

    modport source (output valid, func, entry_number, entry_pos, desired_frame,
                    input ready);
    modport sink (input valid, func, entry_number, entry_pos, desired_frame,
                  output ready);
endinterface

interface kibs_result_if;
    import kibs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic                    exact;
    logic [SLOT_W-1:0]       lower_slot;
    logic [SLOT_W-1:0]       upper_slot;
    logic [KEY_W-1:0]        lower_key;
    logic [KEY_W-1:0]        upper_key;
    logic signed [POS_W-1:0] lower_pos;
    logic signed [POS_W-1:0] upper_pos;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, status, exact, lower_slot, upper_slot, lower_key,
                    upper_key, lower_pos, upper_pos, entry_count,
                    input ready);
    modport sink (input valid, status, exact, lower_slot, upper_slot, lower_key,
                  upper_key, lower_pos, upper_pos, entry_count,
                  output ready);
endinterface

// ===== rtl/core/keyframe_index_bound_search.sv =====
// Channel   Direction  Transfer payload
// item      in         func, entry_number, entry_pos, desired_frame
// result    out        status, exact, lower/upper slot, key, pos, entry_count
// apb       in         psel, penable, pwrite, paddr, pwdata -> prdata, pready
//
// One item is worked on at a time. Clear, unused codes, rejected appends and
// empty searches go from decode straight to the output state; a stored append
// passes through the multiply and write states first. A search makes binary
// search probes (at most 11 for a full table), each a read of the table memory
// followed by a compare. A search by keyframe number with a nonzero distance
// first runs the 4-bit-per-cycle divider.
// Reset clears the entry count and offset; the table memory is not cleared.
// The result register lets the next item be taken while a result is stalled.
module keyframe_index_bound_search
    import kibs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    kibs_item_if.sink             item,
    kibs_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_RDL  = 4'd8;
    localparam logic [3:0] S_RDH  = 4'd9;
    localparam logic [3:0] S_KH   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Configuration registers.
    logic [DIST_W-1:0] dist_reg;
    logic              search_adj_reg;
    logic              disc_reg;

    // Control state.
    logic [3:0]         state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [NUM_W-1:0]   offset_reg;
    logic [NUM_W-1:0]   first_num_reg;
    logic [NUM_W-1:0]   last_num_reg;
    logic               out_valid_reg;

    // Working registers.
    logic [FUNC_W-1:0]       func_reg;
    logic [NUM_W-1:0]        num_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [FRAME_W-1:0]      frame_reg;
    logic [ADJ_W-1:0]        adj_reg;
    logic [FRAME_W-1:0]      want_reg;
    logic [CNT_W-1:0]        lo_p1_reg;
    logic [CNT_W-1:0]        hi_reg;
    logic [SLOT_W-1:0]       mid_reg;
    logic [SLOT_W-1:0]       lo_slot_reg;
    logic [SLOT_W-1:0]       hi_slot_reg;
    logic                    found_reg;
    logic [FRAME_W-1:0]      div_q_reg;
    logic [DIST_W-1:0]       div_r_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    result_t                 res_reg;
    result_t                 out_reg;
    logic [CNT_W-1:0]        out_count_reg;

    // Table memory.
    row_t                    mem [TABLE_DEPTH];
    row_t                    rdata_reg;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    mem_we;

    logic                    cfg_write;
    logic                    out_load;
    logic [STATUS_W-1:0]     dec_status;
    logic [SLOT_W+1:0]       mid_sum;
    logic [SLOT_W-1:0]       mid;
    logic [FRAME_W-1:0]      div_q_next;
    logic [DIST_W-1:0]       div_r_next;
    logic signed [CMP_W-1:0] probe_val;
    logic signed [CMP_W-1:0] want_val;
    logic signed [NUM_W:0]   num_diff;
    logic [DIST_W-1:0]       key_mult;
    logic signed [NUM_W+DIST_W+1:0] key_prod;
    logic [KEY_W-1:0]        row_key;

    // APB register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_DISTANCE: prdata = {{(APB_DATA_W-DIST_W){1'b0}}, dist_reg};
            REG_SEARCH:   prdata = {{(APB_DATA_W-1){1'b0}}, search_adj_reg};
            REG_DISC:     prdata = {{(APB_DATA_W-1){1'b0}}, disc_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg       <= DIST_W'(1);
            search_adj_reg <= 1'b0;
            disc_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_DISTANCE: dist_reg       <= pwdata[DIST_W-1:0];
                REG_SEARCH:   search_adj_reg <= pwdata[0];
                REG_DISC:     disc_reg       <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // Status of the item, decided at decode.
    always_comb
    begin
        dec_status = ST_OK;
        if (func_reg == FUNC_APPEND)
        begin
            if (count_reg >= CNT_W'(TABLE_DEPTH))
                dec_status = ST_FULL;
            else if (count_reg != '0 && num_reg <= last_num_reg)
                dec_status = ST_NOT_INCR;
        end
        else if (func_reg == FUNC_SEARCH && count_reg == '0)
        begin
            dec_status = ST_EMPTY;
        end
    end

    // Midpoint of the open interval (lo, hi), with lo kept as lo + 1.
    assign mid_sum = {1'b0, hi_reg} + {1'b0, lo_p1_reg} - (SLOT_W+2)'(1);
    assign mid     = mid_sum[SLOT_W:1];

    // Divider: DIV_BITS restoring steps per cycle.
    always_comb
    begin
        logic [DIST_W:0] trial;
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial      = {div_r_next, div_q_next[FRAME_W-1]};
            div_q_next = {div_q_next[FRAME_W-2:0], 1'b0};
            if (trial >= {1'b0, dist_reg})
            begin
                trial         = trial - {1'b0, dist_reg};
                div_q_next[0] = 1'b1;
            end
            div_r_next = trial[DIST_W-1:0];
        end
    end

    // Search value and key of the row just read.
    assign num_diff  = $signed({1'b0, rdata_reg.num}) - $signed({1'b0, offset_reg});
    assign probe_val = search_adj_reg ? $signed({2'b00, rdata_reg.adj})
                                      : CMP_W'(num_diff);
    assign want_val  = $signed({{(CMP_W-FRAME_W){1'b0}}, want_reg});
    assign key_mult  = disc_reg ? DIST_W'(1) : dist_reg;
    assign key_prod  = num_diff * $signed({1'b0, key_mult});
    assign row_key   = search_adj_reg ? rdata_reg.adj[KEY_W-1:0] : key_prod[KEY_W-1:0];

    // Memory address and write enable.
    always_comb
    begin
        case (state_reg)
            S_RDL:   rd_addr = lo_slot_reg;
            S_RDH:   rd_addr = hi_slot_reg;
            default: rd_addr = mid;
        endcase
    end

    assign mem_we = (state_reg == S_WR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[SLOT_W-1:0]] <= '{num: num_reg, adj: adj_reg, pos: pos_reg};
        end
        rdata_reg <= mem[rd_addr];
    end

    // Result register toward the sink.
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg       <= res_reg;
            out_count_reg <= count_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_reg.status;
    assign result.exact       = out_reg.exact;
    assign result.lower_slot  = out_reg.lower_slot;
    assign result.upper_slot  = out_reg.upper_slot;
    assign result.lower_key   = out_reg.lower_key;
    assign result.upper_key   = out_reg.upper_key;
    assign result.lower_pos   = out_reg.lower_pos;
    assign result.upper_pos   = out_reg.upper_pos;
    assign result.entry_count = out_count_reg;

    assign item.ready = (state_reg == S_IDLE);

    // Sequencer control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            offset_reg    <= '0;
            first_num_reg <= '0;
            last_num_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    case (func_reg)
                        FUNC_CLEAR:
                        begin
                            count_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        FUNC_APPEND:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                                state_reg <= S_OUT;
                            else if (count_reg != '0 && num_reg <= last_num_reg)
                                state_reg <= S_OUT;
                            else
                                state_reg <= S_MUL;
                        end
                        FUNC_SEARCH:
                        begin
                            if (count_reg == '0)
                                state_reg <= S_OUT;
                            else if (!search_adj_reg && dist_reg != '0)
                                state_reg <= S_DIV;
                            else
                                state_reg <= S_RD;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_MUL: state_reg <= S_WR;
                S_WR:
                begin
                    count_reg    <= count_reg + CNT_W'(1);
                    last_num_reg <= num_reg;
                    if (count_reg == '0)
                        first_num_reg <= num_reg;
                    if (!disc_reg)
                        offset_reg <= (count_reg == '0) ? num_reg : first_num_reg;
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                        state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (probe_val == want_val)
                        state_reg <= S_RDL;
                    else if (probe_val > want_val)
                        state_reg <= ({1'b0, mid_reg} > lo_p1_reg) ? S_RD : S_FIN;
                    else
                        state_reg <= (hi_reg > {1'b0, mid_reg} + CNT_W'(1)) ? S_RD : S_FIN;
                end
                S_FIN: state_reg <= S_RDL;
                S_RDL: state_reg <= S_RDH;
                S_RDH: state_reg <= S_KH;
                S_KH:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg  <= item.func;
                num_reg   <= item.entry_number;
                pos_reg   <= item.entry_pos;
                frame_reg <= item.desired_frame;
            end
            S_DEC:
            begin
                res_reg     <= '{status: dec_status, default: '0};
                lo_p1_reg   <= '0;
                hi_reg      <= count_reg;
                found_reg   <= 1'b0;
                want_reg    <= frame_reg;
                div_q_reg   <= frame_reg;
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
            end
            S_MUL:
            begin
                adj_reg <= {{(ADJ_W-NUM_W){1'b0}}, num_reg}
                           * {{(ADJ_W-DIST_W){1'b0}}, dist_reg};
            end
            S_DIV:
            begin
                div_q_reg   <= div_q_next;
                div_r_reg   <= div_r_next;
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    want_reg <= div_q_next;
            end
            S_RD:
            begin
                mid_reg <= mid;
            end
            S_CMP:
            begin
                if (probe_val == want_val)
                begin
                    found_reg   <= 1'b1;
                    lo_slot_reg <= mid_reg;
                    hi_slot_reg <= mid_reg;
                end
                else if (probe_val > want_val)
                begin
                    hi_reg <= {1'b0, mid_reg};
                end
                else
                begin
                    lo_p1_reg <= {1'b0, mid_reg} + CNT_W'(1);
                end
            end
            S_FIN:
            begin
                // Interval closed: lo = lo_p1 - 1 and hi = lo_p1, both clamped.
                lo_slot_reg <= (lo_p1_reg == '0) ? '0 : SLOT_W'(lo_p1_reg - CNT_W'(1));
                hi_slot_reg <= (hi_reg == count_reg) ? SLOT_W'(count_reg - CNT_W'(1))
                                                     : hi_reg[SLOT_W-1:0];
            end
            S_RDH:
            begin
                res_reg.exact      <= found_reg;
                res_reg.lower_slot <= lo_slot_reg;
                res_reg.upper_slot <= hi_slot_reg;
                res_reg.lower_key  <= row_key;
                res_reg.lower_pos  <= rdata_reg.pos;
            end
            S_KH:
            begin
                res_reg.upper_key <= row_key;
                res_reg.upper_pos <= rdata_reg.pos;
            end
            default: ;
        endcase
    end

    // The entry count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // A table write lands only below the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> count_reg < CNT_W'(TABLE_DEPTH))
        else $error("table write into a full table");

    // A probe is issued only while the search interval is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (hi_reg > lo_p1_reg))
        else $error("probe issued on a closed interval");

    // After an item transfer the input stays closed for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("second item taken while one is in work");

endmodule

// ===== sim/keyframe_index_bound_search_test.sv =====
module keyframe_index_bound_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kibs_pkg::*;

    // Code 3 is not a defined function; the block must leave its state alone.
    localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;

    localparam int  DIRECTED_LEN     = 24;
    localparam int  PHASES           = 10;
    localparam int  FILL_PHASE       = 5;
    localparam int  PHASE_ITEMS      = 60;
    localparam int  LONG_HOLD_CYCLES = 400;
    localparam int  DRAIN_CYCLES     = 60;
    localparam int  REPORT_LIMIT     = 40;
    localparam real TIMEOUT_NS       = 15_000_000.0;

    // Expected content of one result transfer.
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    exact;
        logic [SLOT_W-1:0]       lower_slot;
        logic [SLOT_W-1:0]       upper_slot;
        logic [KEY_W-1:0]        lower_key;
        logic [KEY_W-1:0]        upper_key;
        logic signed [POS_W-1:0] lower_pos;
        logic signed [POS_W-1:0] upper_pos;
        logic [CNT_W-1:0]        entry_count;
    } bounds_t;

    // One row of the directed table. Rows marked typed carry their own status
    // and count; every other field of such a result is zero.
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [NUM_W-1:0]        number;
        logic signed [POS_W-1:0] pos;
        logic [FRAME_W-1:0]      frame;
        logic                    typed;
        logic [STATUS_W-1:0]     status;
        logic [CNT_W-1:0]        entry_count;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    kibs_item_if   item_ch();
    kibs_result_if result_ch();

    keyframe_index_bound_search DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the keyframe table and the registers.
    logic [NUM_W-1:0]        kf_number   [TABLE_DEPTH];
    logic [ADJ_W-1:0]        kf_adjusted [TABLE_DEPTH];
    logic signed [POS_W-1:0] kf_pos      [TABLE_DEPTH];
    int                      kf_count;
    logic [NUM_W-1:0]        kf_offset;
    logic [DIST_W-1:0]       cfg_distance;
    bit                      cfg_by_adjusted;
    bit                      cfg_disc;

    bounds_t       results_due [$];
    directed_row_t directed_rows [DIRECTED_LEN];
    int            mismatches;
    bit            src_idle_on;
    bit            sink_idle_on;
    bit            long_hold_req;

    int phase_distance [PHASES];
    bit phase_by_adj   [PHASES];
    bit phase_disc     [PHASES];

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: got %h, expected %h at %0t ns", what, got, want, $time);
    endtask

    // Value a slot is ordered by in a search.
    function automatic longint search_key(int slot);
        if (cfg_by_adjusted)
            return longint'({16'd0, kf_adjusted[slot]});
        return longint'({32'd0, kf_number[slot]}) - longint'({32'd0, kf_offset});
    endfunction

    // Frame key reported for a slot, wrapped to the key width.
    function automatic logic [KEY_W-1:0] frame_key(int slot);
        longint diff;
        longint mult;
        longint prod;
        if (cfg_by_adjusted)
            return kf_adjusted[slot][KEY_W-1:0];
        diff = longint'({32'd0, kf_number[slot]}) - longint'({32'd0, kf_offset});
        mult = cfg_disc ? 64'sd1 : longint'({48'd0, cfg_distance});
        prod = diff * mult;
        return prod[KEY_W-1:0];
    endfunction

    // Applies one item to the shadow table and returns the result it yields.
    function automatic bounds_t apply_to_index(logic [FUNC_W-1:0] func,
                                               logic [NUM_W-1:0] number,
                                               logic signed [POS_W-1:0] pos,
                                               logic [FRAME_W-1:0] frame);
        bounds_t r;
        longint  lo;
        longint  hi;
        longint  mid;
        longint  want;
        longint  v;
        bit      found;
        r = '0;
        case (func)
            FUNC_CLEAR:
                kf_count = 0;
            FUNC_APPEND:
            begin
                // The full check comes before the ordering check.
                if (kf_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else if (kf_count > 0 && number <= kf_number[kf_count-1])
                    r.status = ST_NOT_INCR;
                else
                begin
                    kf_number[kf_count]   = number;
                    kf_adjusted[kf_count] = {16'd0, number} * {32'd0, cfg_distance};
                    kf_pos[kf_count]      = pos;
                    kf_count++;
                    if (!cfg_disc)
                        kf_offset = kf_number[0];
                end
            end
            FUNC_SEARCH:
            begin
                if (kf_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    lo    = -1;
                    hi    = kf_count;
                    found = 1'b0;
                    want  = longint'({24'd0, frame});
                    if (!cfg_by_adjusted && cfg_distance != 0)
                        want = want / longint'({48'd0, cfg_distance});
                    while (hi - 1 > lo)
                    begin
                        mid = (hi + lo) / 2;
                        v   = search_key(int'(mid));
                        if (v == want)
                        begin
                            lo    = mid;
                            hi    = mid;
                            found = 1'b1;
                            break;
                        end
                        else if (v > want)
                            hi = mid;
                        else
                            lo = mid;
                    end
                    // Without an exact hit, walk outward and clamp to the table.
                    if (!found)
                    begin
                        while (lo >= 0 && search_key(int'(lo)) > want)
                            lo--;
                        while (hi < kf_count && search_key(int'(hi)) < want)
                            hi++;
                        if (lo < 0)
                            lo = 0;
                        if (hi > kf_count - 1)
                            hi = kf_count - 1;
                    end
                    r.exact      = found;
                    r.lower_slot = lo[SLOT_W-1:0];
                    r.upper_slot = hi[SLOT_W-1:0];
                    r.lower_key  = frame_key(int'(lo));
                    r.upper_key  = frame_key(int'(hi));
                    r.lower_pos  = kf_pos[lo];
                    r.upper_pos  = kf_pos[hi];
                end
            end
            default:
                ;
        endcase
        r.entry_count = CNT_W'(kf_count);
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'({$urandom, $urandom});
    endfunction

    // Offers one item, waits for its transfer and records the expected result.
    task automatic send_item(logic [FUNC_W-1:0] func, logic [NUM_W-1:0] number,
                             logic signed [POS_W-1:0] pos, logic [FRAME_W-1:0] frame,
                             bit typed = 1'b0, logic [STATUS_W-1:0] t_status = ST_OK,
                             logic [CNT_W-1:0] t_count = '0);
        bounds_t outcome;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.func          <= func;
        item_ch.entry_number  <= number;
        item_ch.entry_pos     <= pos;
        item_ch.desired_frame <= frame;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        outcome = apply_to_index(func, number, pos, frame);
        if (typed)
        begin
            outcome             = '0;
            outcome.status      = t_status;
            outcome.entry_count = t_count;
        end
        results_due = {results_due, outcome};
    endtask

    // Lets every outstanding result arrive so the block is idle.
    task automatic drain_pipeline();
        item_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic program_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_DISTANCE:
            begin
                cfg_distance = value[DIST_W-1:0];
                stored       = APB_DATA_W'(cfg_distance);
            end
            REG_SEARCH:
            begin
                cfg_by_adjusted = value[0];
                stored          = APB_DATA_W'(cfg_by_adjusted);
            end
            REG_DISC:
            begin
                cfg_disc = value[0];
                stored   = APB_DATA_W'(cfg_disc);
            end
            default:
                stored = '0;
        endcase

        // Read back at the same address.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== stored)
            report_mismatch("register readback", 64'(prdata), 64'(stored));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic. Mostly increasing appends and searches aimed at stored
    // entries; the rest is clears, unused codes and out-of-order appends.
    // In fill mode the table is first filled to the top, and the item budget
    // counts only what follows.
    task automatic run_phase(int n_items, bit fill);
        int                 sent;
        int                 pick;
        int                 slot;
        bit                 filling;
        logic [NUM_W-1:0]   number;
        logic [FRAME_W-1:0] frame;
        longint             base;
        if (fill || $urandom_range(0, 3) != 0)
            send_item(FUNC_CLEAR, $urandom, rand_pos(), FRAME_W'({$urandom, $urandom}));
        sent = 0;
        while (sent < n_items)
        begin
            filling = fill && kf_count < TABLE_DEPTH;
            pick    = $urandom_range(0, 99);
            if (filling)
                pick = (pick < 95) ? 10 : 45;
            else if (fill)
                pick = (pick < 15) ? 10 : (pick < 20) ? 5 : 99;

            if (pick < 4)
                send_item(FUNC_CLEAR, $urandom, rand_pos(), FRAME_W'({$urandom, $urandom}));
            else if (pick < 9)
                send_item(FUNC_IDLE, $urandom, rand_pos(), FRAME_W'({$urandom, $urandom}));
            else if (pick < 40)
            begin
                // Append above the last stored number. A filling run starts low
                // so that the numbers cannot wrap before the table is full.
                if (kf_count == 0)
                    case ($urandom_range(0, 3))
                        0:       number = '0;
                        1:       number = NUM_W'($urandom_range(0, 1000));
                        default: number = fill ? NUM_W'($urandom_range(0, 1 << 20)) : $urandom;
                    endcase
                else
                    number = kf_number[kf_count-1]
                             + $urandom_range(1, 1 << $urandom_range(0, fill ? 12 : 24));
                send_item(FUNC_APPEND, number, rand_pos(), '0);
            end
            else if (pick < 46)
            begin
                // Append at or below the last stored number.
                number = (kf_count > 0) ? kf_number[kf_count-1] - $urandom_range(0, 3)
                                        : (fill ? NUM_W'($urandom_range(0, 1 << 20))
                                                : $urandom);
                send_item(FUNC_APPEND, number, rand_pos(), FRAME_W'($urandom));
            end
            else
            begin
                if (kf_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    slot = $urandom_range(0, kf_count - 1);
                    base = search_key(slot) + (int'($urandom_range(0, 2)) - 1);
                    if (!cfg_by_adjusted && cfg_distance != 0)
                        base = base * longint'({48'd0, cfg_distance})
                               + longint'($urandom_range(0, cfg_distance - 1));
                    frame = base[FRAME_W-1:0];
                end
                else
                    case ($urandom_range(0, 3))
                        0:       frame = '0;
                        1:       frame = '1;
                        default: frame = FRAME_W'({$urandom, $urandom});
                    endcase
                send_item(FUNC_SEARCH, $urandom, rand_pos(), frame);
            end
            if (!filling)
                sent++;
        end
    endtask

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        bounds_t got;
        bounds_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.status      = result_ch.status;
            got.exact       = result_ch.exact;
            got.lower_slot  = result_ch.lower_slot;
            got.upper_slot  = result_ch.upper_slot;
            got.lower_key   = result_ch.lower_key;
            got.upper_key   = result_ch.upper_key;
            got.lower_pos   = result_ch.lower_pos;
            got.upper_pos   = result_ch.upper_pos;
            got.entry_count = result_ch.entry_count;
            if (results_due.size() == 0)
                report_mismatch("unexpected result, status", 64'(got.status), 64'(0));
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.exact !== want.exact)
                    report_mismatch("exact", 64'(got.exact), 64'(want.exact));
                if (got.lower_slot !== want.lower_slot)
                    report_mismatch("lower_slot", 64'(got.lower_slot), 64'(want.lower_slot));
                if (got.upper_slot !== want.upper_slot)
                    report_mismatch("upper_slot", 64'(got.upper_slot), 64'(want.upper_slot));
                if (got.lower_key !== want.lower_key)
                    report_mismatch("lower_key", 64'(got.lower_key), 64'(want.lower_key));
                if (got.upper_key !== want.upper_key)
                    report_mismatch("upper_key", 64'(got.upper_key), 64'(want.upper_key));
                if (got.lower_pos !== want.lower_pos)
                    report_mismatch("lower_pos", 64'(got.lower_pos), 64'(want.lower_pos));
                if (got.upper_pos !== want.upper_pos)
                    report_mismatch("upper_pos", 64'(got.upper_pos), 64'(want.upper_pos));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (long_hold_req)
            begin
                stall         = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else if (rst_n && sink_idle_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 16);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = FUNC_CLEAR;
        item_ch.entry_number  = '0;
        item_ch.entry_pos     = '0;
        item_ch.desired_frame = '0;
        kf_count              = 0;
        kf_offset             = '0;
        cfg_distance          = 16'd1;
        cfg_by_adjusted       = 1'b0;
        cfg_disc              = 1'b0;
        mismatches            = 0;
        src_idle_on           = 1'b1;
        sink_idle_on          = 1'b1;
        long_hold_req         = 1'b0;

        // Reset-time registers: distance 1, search by number, offset tracking on.
        directed_rows = '{
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd0,  1'b1, ST_EMPTY, 11'd0},
            '{FUNC_SEARCH, 32'hFFFF_FFFF, 48'sd0,               '1,     1'b1, ST_EMPTY, 11'd0},
            '{FUNC_IDLE,   32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF,  '1,     1'b1, ST_OK,    11'd0},
            '{FUNC_CLEAR,  32'd0,         48'sd0,               40'd0,  1'b1, ST_OK,    11'd0},
            '{FUNC_APPEND, 32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF,  40'd0,  1'b1, ST_OK,    11'd1},
            '{FUNC_APPEND, 32'd0,         48'sh8000_0000_0000,  40'd0,  1'b1, ST_NOT_INCR, 11'd1},
            '{FUNC_APPEND, 32'hFFFF_FFFF, 48'sd1,               40'd0,  1'b1, ST_NOT_INCR, 11'd1},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd0,  1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               '1,     1'b0, ST_OK,    11'd0},
            '{FUNC_CLEAR,  32'hFFFF_FFFF, -48'sd1,              '1,     1'b1, ST_OK,    11'd0},
            '{FUNC_APPEND, 32'd0,         48'sh8000_0000_0000,  40'd0,  1'b1, ST_OK,    11'd1},
            '{FUNC_APPEND, 32'd5,         -48'sd1,              40'd0,  1'b1, ST_OK,    11'd2},
            '{FUNC_APPEND, 32'd10,        48'sh5555_5555_5555,  40'd0,  1'b1, ST_OK,    11'd3},
            '{FUNC_APPEND, 32'd20,        48'sh2AAA_AAAA_AAAA,  40'd0,  1'b1, ST_OK,    11'd4},
            '{FUNC_APPEND, 32'hFFFF_FFFF, 48'sd0,               40'd0,  1'b1, ST_OK,    11'd5},
            '{FUNC_APPEND, 32'd15,        48'sd7,               40'd0,  1'b1, ST_NOT_INCR, 11'd5},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd0,  1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd5,  1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd7,  1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd10, 1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd25, 1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               40'd3,  1'b0, ST_OK,    11'd0},
            '{FUNC_SEARCH, 32'd0,         48'sd0,               '1,     1'b0, ST_OK,    11'd0},
            '{FUNC_IDLE,   32'd0,         48'sd0,               40'd0,  1'b1, ST_OK,    11'd5}
        };

        // Register settings per phase: both distance extremes, zero distance,
        // disc mode carrying over an old offset, and one phase filling the table.
        phase_distance = '{65535, 65535, 0, 7, 1, $urandom_range(1, 300),
                           $urandom_range(1, 65535), 0, 1, $urandom_range(1, 65535)};
        phase_by_adj   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, $urandom_range(0, 1),
                           1'b0, 1'b1, 1'b0, $urandom_range(0, 1)};
        phase_disc     = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                           1'b1, 1'b1, 1'b0, $urandom_range(0, 1)};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].func, directed_rows[i].number, directed_rows[i].pos,
                      directed_rows[i].frame, directed_rows[i].typed,
                      directed_rows[i].status, directed_rows[i].entry_count);

        for (p = 0; p < PHASES; p++)
        begin
            drain_pipeline();
            program_reg(REG_DISTANCE, APB_DATA_W'(phase_distance[p]));
            program_reg(REG_SEARCH, APB_DATA_W'(phase_by_adj[p]));
            program_reg(REG_DISC, APB_DATA_W'(phase_disc[p]));
            // The last two phases run without idling on either side.
            src_idle_on  = (p < PHASES - 2) && $urandom_range(0, 3) != 0;
            sink_idle_on = (p < PHASES - 2) && $urandom_range(0, 3) != 0;
            // Hold results back long enough that the block stalls its input.
            if (p == 1)
                long_hold_req = 1'b1;
            run_phase(p == FILL_PHASE ? 80 : PHASE_ITEMS, p == FILL_PHASE);
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
